/* src/rpad_pkg.sv */
// Shared types and constants of the Rice-coded polynomial audio decoder.
// No dependencies.
package rpad_pkg;

   localparam int BLOCK_DEPTH = 32768;
   localparam int BLOCK_ADDR_W = $clog2(BLOCK_DEPTH);

   localparam logic CSR_SAMPLE_COUNT = 1'b0;
   localparam logic CSR_STEREO_MODE = 1'b1;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       realign;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel;
      logic               level_last;
      logic               header_error;
   } rsp_type;

   typedef struct packed {
      logic        clear;
      logic        update;
      logic        chan;
      logic [1:0]  order;
      logic [15:0] value;
   } pred_ctl_type;

endpackage

/* src/rpad_ram.sv */
// Single-port-write, single-port-read memory with registered read data.
// No dependencies.
module rpad_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rpad_predictor.sv */
// Fixed polynomial predictors of order 0 to 3 for two channels, 16-bit wrap.
// Depends on rpad_pkg.
module rpad_predictor
   import rpad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pred_ctl_type ctl,
   output logic [15:0]  result
);

   logic [15:0] r0_ff [2];
   logic [15:0] r1_ff [2];
   logic [15:0] r2_ff [2];
   logic [15:0] r0_in, r1_in, r2_in;
   logic [15:0] o0, o1, o2, v;

   always_comb begin
      o0 = r0_ff[ctl.chan];
      o1 = r1_ff[ctl.chan];
      o2 = r2_ff[ctl.chan];
      v = ctl.value;
      case (ctl.order)
         2'd0: begin
            r2_in = v - o0 - o1;
            r1_in = v - o0;
            r0_in = v;
         end
         2'd1: begin
            r2_in = v - o1;
            r1_in = v;
            r0_in = o0 + v;
         end
         2'd2: begin
            r2_in = v;
            r1_in = o1 + v;
            r0_in = o0 + r1_in;
         end
         default: begin
            r2_in = o2 + v;
            r1_in = o1 + r2_in;
            r0_in = o0 + r1_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         r0_ff <= '{default: '0};
         r1_ff <= '{default: '0};
         r2_ff <= '{default: '0};
      end else if (ctl.update) begin
         r0_ff[ctl.chan] <= r0_in;
         r1_ff[ctl.chan] <= r1_in;
         r2_ff[ctl.chan] <= r2_in;
      end
   end

   assign result = r0_in;

endmodule

/* src/rice_polynomial_audio_decoder.sv */
// Each accepted item is one byte whose bits are decoded least significant first, one bit per
// cycle while no completed sample or stalled result port holds the bit sequencer; each sample
// that a byte completes passes through the memory read, prediction and bookkeeping states,
// and sample results go out through the emit states. A header error result is registered as
// its bit is decoded. req_ready is high only while the bit sequencer waits for a byte.
// Depends on rpad_pkg, rpad_ram and rpad_predictor.
module rice_polynomial_audio_decoder
   import rpad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_BIT, S_READ, S_PRED, S_FINISH, S_EMIT_A, S_EMIT_B
   } state_type;

   typedef enum logic [3:0] {
      PH_MARK, PH_BSHIFT, PH_OSHIFT, PH_SUM, PH_ORDER, PH_WIDTH, PH_LOW, PH_RUN, PH_HALT
   } phase_type;

   state_type   state_ff;
   phase_type   phase_ff;
   logic [31:0] count_ff;
   logic        stereo_ff;
   logic [7:0]  byte_ff;
   logic [2:0]  bit_idx_ff;
   logic [15:0] acc_ff;
   logic [4:0]  left_ff;
   logic [15:0] run_ff;
   logic [3:0]  width_ff, bshift_ff, oshift_ff;
   logic [1:0]  order_ff;
   logic        sum_ff, chan_ff, pair_ff, last_ff;
   logic [15:0] bidx_ff;
   logic [31:0] sleft_ff;
   logic [15:0] res_ff, a_ff, b_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic         cur_bit, out_free, rsp_load;
   logic [15:0]  acc_new, field_val, shift_src, rd_data, raw, zz, zz_u;
   logic [4:0]   left_new;
   logic         field_done;
   logic [15:0]  pred_res;
   pred_ctl_type pred_ctl;
   logic [31:0]  full_len, blk_len, sleft_rem;
   logic         end_block, end_level, in_range, ram_we;

   assign cur_bit = byte_ff[bit_idx_ff];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = out_free && ((state_ff == S_BIT && phase_ff == PH_MARK && !cur_bit) ||
                                  state_ff == S_EMIT_A || state_ff == S_EMIT_B);
   assign acc_new = {cur_bit, acc_ff[15:1]};
   assign left_new = (left_ff != 5'd0) ? left_ff - 5'd1 : 5'd0;
   assign field_done = (left_new == 5'd0);

   always_comb begin
      case (phase_ff)
         PH_ORDER: shift_src = acc_new >> 14;
         PH_LOW:   shift_src = acc_new >> (5'd16 - {1'b0, width_ff});
         default:  shift_src = acc_new >> 12;
      endcase
   end
   assign field_val = shift_src;

   assign raw = (run_ff << width_ff) | acc_ff;
   assign zz_u = (raw + 16'd1) >> 1;
   assign zz = raw[0] ? (16'd0 - zz_u) : (raw >> 1);

   assign full_len = 32'd1 << bshift_ff;
   assign blk_len = (sleft_ff < full_len) ? sleft_ff : full_len;
   assign end_block = ({16'd0, bidx_ff} + 32'd1) >= blk_len;
   assign end_level = end_block && (blk_len == sleft_ff);
   assign sleft_rem = sleft_ff - blk_len;
   assign in_range = bidx_ff < 16'(BLOCK_DEPTH);
   assign ram_we = (state_ff == S_FINISH) && stereo_ff && !chan_ff && in_range;

   always_comb begin
      pred_ctl.clear = 1'b0;
      pred_ctl.update = (state_ff == S_PRED);
      pred_ctl.chan = chan_ff;
      pred_ctl.order = order_ff;
      pred_ctl.value = zz;
      if (state_ff == S_IDLE && req_valid && req_data.realign) begin
         pred_ctl.clear = 1'b1;
      end
      if (state_ff == S_BIT && (phase_ff == PH_SUM ||
            (phase_ff == PH_OSHIFT && field_done && !stereo_ff))) begin
         pred_ctl.clear = 1'b1;
      end
   end

   rpad_predictor u_pred (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pred_ctl),
      .result (pred_res)
   );

   rpad_ram #(.DEPTH(BLOCK_DEPTH), .WIDTH(16)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (bidx_ff[BLOCK_ADDR_W-1:0]),
      .wr_data (res_ff),
      .rd_addr (bidx_ff[BLOCK_ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_MARK;
         count_ff <= '0;
         stereo_ff <= 1'b0;
         bit_idx_ff <= '0;
         acc_ff <= '0;
         left_ff <= '0;
         run_ff <= '0;
         width_ff <= '0;
         order_ff <= '0;
         bshift_ff <= '0;
         oshift_ff <= '0;
         sum_ff <= 1'b0;
         chan_ff <= 1'b0;
         bidx_ff <= '0;
         sleft_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLE_COUNT: count_ff <= csr_wdata;
               CSR_STEREO_MODE:  stereo_ff <= csr_wdata[0];
               default:          count_ff <= count_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  byte_ff <= req_data.packed_byte;
                  bit_idx_ff <= '0;
                  state_ff <= S_BIT;
                  if (req_data.realign) begin
                     phase_ff <= PH_MARK;
                     acc_ff <= '0;
                     left_ff <= '0;
                     run_ff <= '0;
                     chan_ff <= 1'b0;
                     bidx_ff <= '0;
                     sleft_ff <= '0;
                  end
               end
            end
            S_BIT: begin
               if (phase_ff == PH_RUN && cur_bit) begin
                  state_ff <= S_READ;
               end else if (phase_ff == PH_MARK && !cur_bit && !out_free) begin
                  state_ff <= S_BIT;
               end else begin
                  state_ff <= (bit_idx_ff == 3'd7) ? S_IDLE : S_BIT;
                  bit_idx_ff <= bit_idx_ff + 3'd1;
                  case (phase_ff)
                     PH_MARK: begin
                        if (cur_bit) begin
                           phase_ff <= PH_BSHIFT;
                           acc_ff <= '0;
                           left_ff <= 5'd4;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= '{sample: '0, channel: 1'b0, level_last: 1'b0,
                                       header_error: 1'b1};
                           phase_ff <= PH_HALT;
                        end
                     end
                     PH_BSHIFT, PH_OSHIFT, PH_ORDER, PH_WIDTH, PH_LOW: begin
                        if (field_done) begin
                           case (phase_ff)
                              PH_BSHIFT: begin
                                 bshift_ff <= field_val[3:0];
                                 phase_ff <= PH_OSHIFT;
                                 acc_ff <= '0;
                                 left_ff <= 5'd4;
                              end
                              PH_OSHIFT: begin
                                 oshift_ff <= field_val[3:0];
                                 acc_ff <= '0;
                                 if (stereo_ff) begin
                                    phase_ff <= PH_SUM;
                                    left_ff <= 5'd1;
                                 end else begin
                                    sum_ff <= 1'b0;
                                    sleft_ff <= count_ff;
                                    chan_ff <= 1'b0;
                                    bidx_ff <= '0;
                                    phase_ff <= (count_ff == 32'd0) ? PH_MARK : PH_ORDER;
                                    left_ff <= 5'd2;
                                 end
                              end
                              PH_ORDER: begin
                                 order_ff <= field_val[1:0];
                                 phase_ff <= PH_WIDTH;
                                 acc_ff <= '0;
                                 left_ff <= 5'd4;
                              end
                              PH_WIDTH: begin
                                 width_ff <= field_val[3:0];
                                 run_ff <= '0;
                                 phase_ff <= (field_val[3:0] == 4'd0) ? PH_RUN : PH_LOW;
                                 acc_ff <= '0;
                                 left_ff <= {1'b0, field_val[3:0]};
                              end
                              default: begin
                                 acc_ff <= field_val;
                                 left_ff <= left_new;
                                 run_ff <= '0;
                                 phase_ff <= PH_RUN;
                              end
                           endcase
                        end else begin
                           acc_ff <= acc_new;
                           left_ff <= left_new;
                        end
                     end
                     PH_SUM: begin
                        sum_ff <= cur_bit;
                        sleft_ff <= count_ff;
                        chan_ff <= 1'b0;
                        bidx_ff <= '0;
                        phase_ff <= (count_ff == 32'd0) ? PH_MARK : PH_ORDER;
                        acc_ff <= '0;
                        left_ff <= 5'd2;
                     end
                     PH_RUN: run_ff <= run_ff + 16'd1;
                     default: phase_ff <= PH_HALT;
                  endcase
               end
            end
            S_READ: state_ff <= S_PRED;
            S_PRED: begin
               res_ff <= pred_res;
               a_ff <= in_range ? rd_data : 16'd0;
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               pair_ff <= stereo_ff;
               last_ff <= end_level;
               b_ff <= res_ff + ((stereo_ff && sum_ff) ? a_ff : 16'd0);
               if (stereo_ff && !chan_ff) begin
                  state_ff <= (bit_idx_ff == 3'd7) ? S_IDLE : S_BIT;
                  bit_idx_ff <= bit_idx_ff + 3'd1;
               end else begin
                  state_ff <= stereo_ff ? S_EMIT_A : S_EMIT_B;
               end
               if (!end_block) begin
                  bidx_ff <= bidx_ff + 16'd1;
                  run_ff <= '0;
                  acc_ff <= '0;
                  phase_ff <= (width_ff == 4'd0) ? PH_RUN : PH_LOW;
                  left_ff <= {1'b0, width_ff};
               end else begin
                  bidx_ff <= '0;
                  acc_ff <= '0;
                  left_ff <= 5'd2;
                  if (stereo_ff && !chan_ff) begin
                     chan_ff <= 1'b1;
                     phase_ff <= PH_ORDER;
                  end else begin
                     chan_ff <= 1'b0;
                     sleft_ff <= sleft_rem;
                     phase_ff <= (sleft_rem == 32'd0) ? PH_MARK : PH_ORDER;
                  end
               end
            end
            S_EMIT_A: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{sample: a_ff << oshift_ff, channel: 1'b0, level_last: 1'b0,
                              header_error: 1'b0};
                  state_ff <= S_EMIT_B;
               end
            end
            S_EMIT_B: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{sample: b_ff << oshift_ff, channel: pair_ff,
                              level_last: last_ff, header_error: 1'b0};
                  state_ff <= (bit_idx_ff == 3'd7) ? S_IDLE : S_BIT;
                  bit_idx_ff <= bit_idx_ff + 3'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.header_error |-> rsp_data.sample == 16'sd0 && !rsp_data.level_last)
      else $error("header error item carries sample data");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT && !(req_valid && req_ready && req_data.realign)
      |=> phase_ff == PH_HALT)
      else $error("decoder left halt without realign");

   a_read_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_PRED)
      else $error("memory read not followed by prediction");

endmodule
